// ----- src/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and character codes for the serial line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_BS,
		OP_BREAK
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  data;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_BS_SP,
		BK_BS_END,
		BK_DUMP
	} back_state_t;

endpackage

`default_nettype wire

// ----- src/serial_line_editor_echo.sv -----
// ----------------------------------------------------------------------------
// serial_line_editor_echo
// Line editor for a received byte stream: echoes printable bytes and
// backspace, and streams the finished line on cr or lf.
//
//   channel   signals                                 direction
//   input     in_valid, in_ready, rx_byte             request in
//   output    out_valid, out_ready, out_kind,         request out
//             out_byte, out_last
//
// a request yields its results at one per cycle while out_ready is high:
// one result for a printable byte, three for backspace, and for a line end
// an lf echo followed by the stored line (up to LINE_CAPACITY - 1 bytes).
// a two-entry command queue lets input be taken while the back end is
// still busy; a stalled output holds the queue.
// reset clears length, break-pair mark, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_editor_echo import sle_pkg::*; #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_kind,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;

	sle_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	sle_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	sle_back #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire

// ----- src/sle_front.sv -----
// ----------------------------------------------------------------------------
// sle_front
// Accepts received bytes, tracks line length and the break-pair mark, and
// turns each byte that has an effect into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front import sle_pkg::*; #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            cmd_valid,
	input  wire logic       cmd_ready,
	output cmd_t            cmd
);

	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int LEN_W = $clog2(LINE_CAPACITY);

	logic [LEN_W-1:0] len_q;
	logic             swallow_q;
	logic             fire;
	logic             is_break;
	logic             is_bs;
	logic             is_print;
	logic             has_room;
	logic             not_empty;

	assign in_ready  = cmd_ready;
	assign fire      = in_valid && in_ready;

	always_comb begin
		is_break  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
		is_bs     = (rx_byte == CH_BS);
		is_print  = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
		has_room  = (len_q < LEN_W'(DEPTH));
		not_empty = (len_q != '0);

		cmd.data = rx_byte;
		if (is_break) begin
			cmd.op = OP_BREAK;
		end else if (is_bs) begin
			cmd.op = OP_BS;
		end else begin
			cmd.op = OP_APPEND;
		end

		cmd_valid = in_valid && ((is_break && !swallow_q) || (is_bs && not_empty) ||
			(is_print && has_room));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			swallow_q <= 1'b0;
		end else if (fire) begin
			if (is_break) begin
				// second half of a cr/lf pair is dropped
				swallow_q <= !swallow_q;
				if (!swallow_q) begin
					len_q <= '0;
				end
			end else begin
				swallow_q <= 1'b0;
				if (is_bs && not_empty) begin
					len_q <= len_q - LEN_W'(1);
				end else if (is_print && has_room) begin
					len_q <= len_q + LEN_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/sle_fifo.sv -----
// ----------------------------------------------------------------------------
// sle_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_fifo import sle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/sle_back.sv -----
// ----------------------------------------------------------------------------
// sle_back
// Carries out queued commands: holds the line store, produces echo bytes and
// streams the stored line on a line end, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back import sle_pkg::*; #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire cmd_t       cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_kind,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int LEN_W = $clog2(LINE_CAPACITY);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rdata_q;

	back_state_t      st_q;
	back_state_t      st_d;
	logic [LEN_W-1:0] blen_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] dump_len_q;
	logic [LEN_W-1:0] rd_addr;
	logic             slot_free;
	logic             dump_end;
	logic             emit;
	logic             emit_kind;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic             mem_we;
	logic             start_dump;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	assign slot_free = !out_valid_q || out_ready;
	assign dump_end  = ((idx_q + LEN_W'(1)) == dump_len_q);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: begin
				if (cmd_valid && slot_free) begin
					case (cmd.op)
						OP_BS: begin
							st_d = BK_BS_SP;
						end
						OP_BREAK: begin
							if (blen_q != '0) begin
								st_d = BK_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_BS_SP: begin
				if (slot_free) begin
					st_d = BK_BS_END;
				end
			end
			BK_BS_END: begin
				if (slot_free) begin
					st_d = BK_IDLE;
				end
			end
			BK_DUMP: begin
				if (slot_free && dump_end) begin
					st_d = BK_IDLE;
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready  = 1'b0;
		emit       = 1'b0;
		emit_kind  = KIND_ECHO;
		emit_byte  = cmd.data;
		emit_last  = 1'b0;
		mem_we     = 1'b0;
		start_dump = 1'b0;
		rd_addr    = idx_q;
		case (st_q)
			BK_IDLE: begin
				cmd_ready = slot_free;
				if (cmd_valid && slot_free) begin
					emit = 1'b1;
					case (cmd.op)
						OP_APPEND: begin
							mem_we    = 1'b1;
							emit_last = 1'b1;
						end
						OP_BS: begin
							emit_byte = CH_BS;
						end
						OP_BREAK: begin
							emit_byte  = CH_LF;
							emit_last  = (blen_q == '0);
							start_dump = 1'b1;
							rd_addr    = '0;
						end
						default: begin
						end
					endcase
				end
			end
			BK_BS_SP: begin
				emit      = slot_free;
				emit_byte = CH_SPACE;
			end
			BK_BS_END: begin
				emit      = slot_free;
				emit_byte = CH_BS;
				emit_last = 1'b1;
			end
			BK_DUMP: begin
				emit      = slot_free;
				emit_kind = KIND_LINE;
				emit_byte = rdata_q;
				emit_last = dump_end;
				// prefetch the next character while this one goes out
				if (slot_free && !dump_end) begin
					rd_addr = idx_q + LEN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[blen_q] <= cmd.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			blen_q      <= '0;
			idx_q       <= '0;
			dump_len_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_valid && cmd_ready) begin
				case (cmd.op)
					OP_APPEND: begin
						blen_q <= blen_q + LEN_W'(1);
					end
					OP_BS: begin
						blen_q <= blen_q - LEN_W'(1);
					end
					OP_BREAK: begin
						blen_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (start_dump) begin
				dump_len_q <= blen_q;
				idx_q      <= '0;
			end else if (st_q == BK_DUMP && emit) begin
				idx_q <= idx_q + LEN_W'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for serial_line_editor_echo. A queue of received bytes
// is streamed in with random bursts and gaps while the output side stalls on
// its own pattern. Every accepted request is run through a line-editor
// predictor, and each output result is checked field by field against the
// oldest predicted echo or line byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import sle_pkg::*;

	localparam int LINE_CAPACITY = 32;
	localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
	localparam int RANDOM_ITEMS  = 130;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} echo_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       out_kind;
	logic [7:0] out_byte;
	logic       out_last;

	// stimulus and expectations
	logic [7:0]   rx_stream[$];
	echo_result_t expected_echo_q[$];
	int           err_count = 0;
	int           req_count = 0;
	int           result_count = 0;
	int           line_ends = 0;
	int           full_drops = 0;
	logic         req_accepted = 1'b0;

	// predictor state
	logic [7:0]  line_chars[STORE_DEPTH];
	int unsigned line_len = 0;
	logic        break_seen = 1'b0;

	serial_line_editor_echo #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	always #5 clk = ~clk;

	task automatic queue_byte(input logic [7:0] b);
		rx_stream.push_back(b);
	endtask

	task automatic queue_printables(input int n);
		for (int i = 0; i < n; i++)
			queue_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
	endtask

	// line editor: works out the echo and line bytes one request causes
	task automatic edit_line(input logic [7:0] b);
		echo_result_t res[$];
		echo_result_t r;
		r.last = 1'b0;
		if (b == CH_CR || b == CH_LF) begin
			if (break_seen) begin
				// second half of a cr/lf pair
				break_seen = 1'b0;
			end else begin
				break_seen = 1'b1;
				line_ends++;
				r.kind = KIND_ECHO;
				r.data = CH_LF;
				res.push_back(r);
				for (int i = 0; i < line_len; i++) begin
					r.kind = KIND_LINE;
					r.data = line_chars[i];
					res.push_back(r);
				end
				line_len = 0;
			end
		end else begin
			break_seen = 1'b0;
			if (b == CH_BS) begin
				if (line_len != 0) begin
					line_len--;
					r.kind = KIND_ECHO;
					r.data = CH_BS;
					res.push_back(r);
					r.data = CH_SPACE;
					res.push_back(r);
					r.data = CH_BS;
					res.push_back(r);
				end
			end else if (b >= CH_SPACE && b <= CH_TILDE) begin
				if (line_len < STORE_DEPTH) begin
					line_chars[line_len] = b;
					line_len++;
					r.kind = KIND_ECHO;
					r.data = b;
					res.push_back(r);
				end else begin
					full_drops++;
				end
			end
		end
		if (res.size() != 0)
			res[res.size() - 1].last = 1'b1;
		foreach (res[i])
			expected_echo_q.push_back(res[i]);
	endtask

	// sender: bursts of requests separated by random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_accepted) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (rx_stream.size() != 0) begin
					in_valid <= 1'b1;
					rx_byte <= rx_stream.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 3);
							2: gap_left = $urandom_range(4, 12);
							default: gap_left = $urandom_range(20, 60);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: out_ready follows a stall mode that is redrawn at random
	int unsigned stall_cyc = 0;
	int          stall_mode = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			stall_cyc++;
			if (stall_cyc % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~(stall_cyc[1] & stall_cyc[2]);
			endcase
		end
	end

	// monitor: check results, then predict from the accepted request
	always @(posedge clk) begin
		echo_result_t e;
		req_accepted <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_echo_q.size() == 0) begin
					$error("unexpected result kind %0d byte 0x%02h last %0d",
						out_kind, out_byte, out_last);
					err_count++;
				end else begin
					e = expected_echo_q.pop_front();
					if (out_kind !== e.kind) begin
						$error("out_kind expected %0d got %0d", e.kind, out_kind);
						err_count++;
					end
					if (out_byte !== e.data) begin
						$error("out_byte expected 0x%02h got 0x%02h", e.data, out_byte);
						err_count++;
					end
					if (out_last !== e.last) begin
						$error("out_last expected %0d got %0d", e.last, out_last);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				req_count++;
				edit_line(rx_byte);
			end
		end
	end

	initial begin
		int seq_kind;
		int n;
		// directed: empty line end, pair swallow, extremes, ignored codes, edits
		queue_byte(CH_CR);
		queue_byte(CH_LF);
		queue_byte(CH_LF);
		queue_byte(CH_BS);
		queue_byte(CH_SPACE);
		queue_byte(CH_TILDE);
		queue_byte(8'h1F);
		queue_byte(8'h7F);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h80);
		queue_byte(8'h41);
		queue_byte(CH_BS);
		queue_byte(CH_BS);
		queue_byte(8'h7A);
		queue_byte(CH_CR);
		queue_byte(CH_LF);
		queue_byte(CH_CR);
		queue_byte(8'h71);
		queue_byte(CH_LF);
		queue_byte(8'h77);
		queue_byte(CH_CR);
		queue_byte(CH_BS);
		queue_byte(CH_CR);
		queue_byte(CH_CR);

		// random lines; the first one runs the store to near or past capacity
		seq_kind = 1;
		while (rx_stream.size() < RANDOM_ITEMS) begin
			case (seq_kind)
				0: begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						queue_byte(8'($urandom_range(0, 255)));
				end
				1: begin
					queue_printables($urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 5));
					queue_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
				end
				2: begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						queue_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
				end
				default: begin
					n = $urandom_range(0, 12);
					for (int i = 0; i < n; i++) begin
						case ($urandom_range(0, 9))
							0, 1: queue_byte(CH_BS);
							2: queue_byte(8'($urandom_range(0, 255)));
							default: queue_printables(1);
						endcase
					end
					case ($urandom_range(0, 5))
						0: queue_byte(CH_CR);
						1: queue_byte(CH_LF);
						2: begin
							queue_byte(CH_CR);
							queue_byte(CH_LF);
						end
						3: begin
							queue_byte(CH_LF);
							queue_byte(CH_CR);
						end
						4: queue_byte(CH_CR);
						default: ;
					endcase
				end
			endcase
			seq_kind = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(0, 9);
			if (seq_kind == 1 && $urandom_range(0, 1) == 0)
				seq_kind = 3;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_stream.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_echo_q.size() != 0)
			@(posedge clk);
		repeat (2 * LINE_CAPACITY) @(posedge clk);

		$display("requests sent %0d, results checked %0d", req_count, result_count);
		$display("line ends %0d, bytes dropped on a full line %0d", line_ends, full_drops);
		if (err_count == 0 && expected_echo_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
